/* sv/rfce_pkg.sv */
// shared types and constants of the row fir with clamped edges
package rfce_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int DEF_MAX_ORDER    = 7;
    localparam int DEF_COEFF_BITS   = 16;
    localparam int ORD_BITS         = 3;
    localparam int POS_BITS         = 4;
    localparam int POS_LIMIT        = 15;
    localparam int CFG_BITS         = 64;
    localparam int CFG_IDX_BITS     = 2;
    localparam int NUM_HALF_COEFFS  = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_LO = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_HI = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANTI    = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_value;
        logic                          last_in_row;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_value;
        logic                          run_last;
        logic                          row_done;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic tap;
        logic write_out;
        logic next_result;
    } t_dp_cmd;

    typedef struct packed {
        logic has_result;
        logic last_tap;
        logic last_result;
        logic out_free;
    } t_dp_stat;

endpackage

/* sv/rfce_ctrl.sv */
// controller state machine: sequences taps and results of one word
module rfce_ctrl
    import rfce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TAP   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.has_result) begin
                        n_state = S_TAP;
                    end
                end
            end
            S_TAP: begin
                o_cmd.tap = 1'b1;
                if (i_stat.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            // last product lands in the accumulator
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.write_out = 1'b1;
                    if (i_stat.last_result) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_result = 1'b1;
                        n_state = S_TAP;
                    end
                end
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* sv/rfce_dp.sv */
// datapath: config registers, sample window, shared multiply-accumulate, output register
module rfce_dp
    import rfce_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int COEFF_BITS = DEF_COEFF_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  t_in_word                i_in_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output t_out_word               o_out_data
);

    localparam int WIN_DEPTH = 2 * MAX_ORDER + 1;
    localparam int JW        = $clog2(WIN_DEPTH);
    localparam int OFF_BITS  = JW + 1;
    localparam int CMP_BITS  = OFF_BITS + POS_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 4;
    localparam int EXT_BITS  = 2 * CFG_BITS;

    localparam logic signed [ACC_BITS-1:0] RND =
        {{(ACC_BITS-COEFF_BITS+1){1'b0}}, 1'b1, {(COEFF_BITS-2){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    logic [CFG_BITS-1:0]  r_coef_lo;
    logic [CFG_BITS-1:0]  r_coef_hi;
    logic [ORD_BITS-1:0]  r_order;
    logic                 r_anti;

    logic signed [SAMPLE_BITS-1:0] r_win [WIN_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic [POS_BITS-1:0]  r_row_pos;
    logic [POS_BITS-1:0]  r_seen;
    logic                 r_last;
    logic [ORD_BITS-1:0]  r_d;
    logic [JW-1:0]        r_j;

    logic signed [PROD_BITS-1:0] r_prod;
    logic                 r_prod_neg;
    logic                 r_prod_vld;
    logic signed [ACC_BITS-1:0]  r_acc;

    logic                 r_out_vld;
    t_out_word            r_out_data;

    logic [EXT_BITS-1:0]  w_lo_ext;
    logic [EXT_BITS-1:0]  w_hi_ext;
    logic signed [COEFF_BITS-1:0] w_lane [NUM_HALF_COEFFS];
    logic [ORD_BITS-1:0]  w_ord;
    logic [ORD_BITS-1:0]  w_d_start;
    logic signed [OFF_BITS-1:0] w_tdiff;
    logic signed [OFF_BITS-1:0] w_abs;
    logic signed [OFF_BITS-1:0] w_off;
    logic [ORD_BITS-1:0]  w_k;
    logic                 w_neg;
    logic signed [COEFF_BITS-1:0]  w_coef;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [ACC_BITS-1:0]    w_sum;
    logic signed [ACC_BITS-1:0]    w_shr;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    // lane bits above bit 63 of a register read as zero
    assign w_lo_ext = {{CFG_BITS{1'b0}}, r_coef_lo};
    assign w_hi_ext = {{CFG_BITS{1'b0}}, r_coef_hi};

    always_comb begin
        for (int l = 0; l < NUM_HALF_COEFFS / 2; l++) begin
            w_lane[l]   = w_lo_ext[l*COEFF_BITS +: COEFF_BITS];
            w_lane[l+4] = w_hi_ext[l*COEFF_BITS +: COEFF_BITS];
        end
    end

    assign w_ord = (r_order > ORD_BITS'(MAX_ORDER)) ? ORD_BITS'(MAX_ORDER) : r_order;
    assign w_d_start = (i_in_data.last_in_row && (r_row_pos < POS_BITS'(w_ord)))
                     ? ORD_BITS'(r_row_pos) : w_ord;

    // tap t = j - order, sample offset d - t from the newest sample
    assign w_tdiff = OFF_BITS'(r_j) - OFF_BITS'(w_ord);
    assign w_abs   = w_tdiff[OFF_BITS-1] ? -w_tdiff : w_tdiff;
    assign w_k     = w_abs[ORD_BITS-1:0];
    assign w_neg   = r_anti && !w_tdiff[OFF_BITS-1];
    assign w_off   = OFF_BITS'(r_d) + OFF_BITS'(w_ord) - OFF_BITS'(r_j);
    assign w_coef  = w_lane[w_k];

    always_comb begin
        if (w_off[OFF_BITS-1]) begin
            w_sample = r_win[0];
        end else if (CMP_BITS'($unsigned(w_off)) > CMP_BITS'(r_seen)) begin
            w_sample = r_left;
        end else begin
            w_sample = r_win[w_off[JW-1:0]];
        end
    end

    assign w_prod = w_coef * w_sample;

    // round half up, then saturate
    assign w_sum = r_acc + RND;
    assign w_shr = w_sum >>> (COEFF_BITS - 1);
    always_comb begin
        if (w_shr > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_shr < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_shr[SAMPLE_BITS-1:0];
        end
    end

    assign o_stat.has_result  = i_in_data.last_in_row || (r_row_pos >= POS_BITS'(w_ord));
    assign o_stat.last_tap    = (r_j == JW'({w_ord, 1'b0}));
    assign o_stat.last_result = !r_last || (r_d == '0);
    assign o_stat.out_free    = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_lo  <= '0;
            r_coef_hi  <= '0;
            r_order    <= ORD_BITS'(1);
            r_anti     <= 1'b0;
            r_row_pos  <= '0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COEF_LO: r_coef_lo <= i_cfg_data;
                    CFG_COEF_HI: r_coef_hi <= i_cfg_data;
                    CFG_ORDER:   r_order   <= i_cfg_data[ORD_BITS-1:0];
                    CFG_ANTI:    r_anti    <= i_cfg_data[0];
                endcase
            end
            if (i_cmd.accept) begin
                if (i_in_data.last_in_row) begin
                    r_row_pos <= '0;
                end else if (r_row_pos < POS_BITS'(POS_LIMIT)) begin
                    r_row_pos <= r_row_pos + 1'b1;
                end
            end
            r_prod_vld <= i_cmd.tap;
            if (i_cmd.write_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0] <= i_in_data.pixel_value;
            if (r_row_pos == '0) begin
                r_left <= i_in_data.pixel_value;
            end
            r_seen <= r_row_pos;
            r_last <= i_in_data.last_in_row;
            r_d    <= w_d_start;
        end else if (i_cmd.next_result) begin
            r_d <= r_d - 1'b1;
        end
        if (i_cmd.accept || i_cmd.next_result) begin
            r_j   <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.tap) begin
                r_j <= r_j + 1'b1;
            end
            if (r_prod_vld) begin
                r_acc <= r_prod_neg ? r_acc - ACC_BITS'(r_prod) : r_acc + ACC_BITS'(r_prod);
            end
        end
        if (i_cmd.tap) begin
            r_prod     <= w_prod;
            r_prod_neg <= w_neg;
        end
        if (i_cmd.write_out) begin
            r_out_data.filtered_value <= w_sat;
            r_out_data.run_last       <= o_stat.last_result;
            r_out_data.row_done       <= r_last && (r_d == '0);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

/* sv/row_fir_clamped_edges.sv */
// top level of the row fir filter with replicated row borders
//
//  channel   direction  handshake              payload
//  cfg       in         i_cfg_we               i_cfg_index, i_cfg_data
//  in        in         i_in_valid/o_in_stall  i_in_data (t_in_word)
//  out       out        o_out_valid/i_out_stall o_out_data (t_out_word)
//
// a word that gives no result is only accepted; a word with results stalls
// the input while the single shared multiply-accumulate walks the 2 * order + 1
// taps of each result one per cycle, then drains and writes each result.
// reset is synchronous and active low; no clearing pass is needed.
// one finished result waits in the output register while the next is computed;
// a stalled output holds the controller only when a second result is ready.
module row_fir_clamped_edges
    import rfce_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int COEFF_BITS = DEF_COEFF_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_word                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_word               o_out_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rfce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    rfce_dp #(
        .MAX_ORDER  (MAX_ORDER),
        .COEFF_BITS (COEFF_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write_out |-> (!o_out_valid || !i_out_stall))
        else $error("result written over a waiting word");

    a_run_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.write_out && w_stat.last_result) |=> (o_out_valid && o_out_data.run_last))
        else $error("last result of a word lost its run_last flag");

    a_row_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_done) |-> o_out_data.run_last)
        else $error("row_done without run_last");

    // no new word while taps of the current one are in flight
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !w_cmd.tap && !w_cmd.write_out)
        else $error("word accepted during a result computation");

endmodule
